@@ hw/rtl/vuof_pkg.sv @@
// vuof_pkg: shared constants and types of the voxel upper outlier filter
// no dependencies
package vuof_pkg;
   localparam int MAX_DIM    = 32;
   localparam int COUNT_BITS = 11;
   localparam int DIM_BITS   = $clog2(MAX_DIM);
   localparam int ADDR_BITS  = 3 * DIM_BITS;
   localparam int CELLS      = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int COORD_BITS = 24;
   localparam int CS_BITS    = 20;
   localparam int CSR_BITS   = 20;
   localparam int IDX_BITS   = 3;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [1:0] KIND_LOAD     = 2'd0;
   localparam logic [1:0] KIND_SCAN     = 2'd1;
   localparam logic [1:0] KIND_CLASSIFY = 2'd2;
   localparam logic [1:0] KIND_CLEAR    = 2'd3;

   localparam logic [IDX_BITS-1:0] REG_CELL_SIZE = 3'd0;
   localparam logic [IDX_BITS-1:0] REG_DIM_X     = 3'd1;
   localparam logic [IDX_BITS-1:0] REG_DIM_Y     = 3'd2;
   localparam logic [IDX_BITS-1:0] REG_DIM_Z     = 3'd3;
   localparam logic [IDX_BITS-1:0] REG_THRESHOLD = 3'd4;
   localparam logic [IDX_BITS-1:0] REG_LEVEL_GAP = 3'd5;

   typedef struct packed {
      logic [1:0]            kind;
      logic [COORD_BITS-1:0] coord_x;
      logic [COORD_BITS-1:0] coord_y;
      logic [COORD_BITS-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic                  removed;
      logic [10:0]           voxel_count;
   } rsp_type;
endpackage

@@ hw/rtl/vuof_if.sv @@
// vuof_if: valid/ready channel carrying one payload
// depends on vuof_pkg
interface vuof_req_if import vuof_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface vuof_rsp_if import vuof_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/voxel_upper_outlier_filter_unit.sv @@
// voxel_upper_outlier_filter_unit: voxel grid with upper outlier scan
// depends on vuof_pkg and vuof_if
// load/classify: 3 serial divides plus memory access
// scan: a mark-clear sweep over all MAX_DIM^3 cells, then per column a walk down the levels,
//   plus a neighbour check for each candidate voxel
// clear: one sweep over all MAX_DIM^3 cells; one transaction at a time
// reset (synchronous, active high): a sweep clearing the grid before the first transaction
module voxel_upper_outlier_filter_unit import vuof_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   vuof_req_if.sink            req,
   vuof_rsp_if.source          rsp,
   input  logic                csr_write_enable,
   input  logic [IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0] csr_data
);
   localparam logic [3:0] ST_CLEAR = 4'd0, ST_IDLE = 4'd1, ST_DIV = 4'd2, ST_LRD = 4'd3,
      ST_LWR = 4'd4, ST_MCLR = 4'd5, ST_COL = 4'd6, ST_CRD = 4'd7, ST_CCHK = 4'd8,
      ST_NRD = 4'd9, ST_NCHK = 4'd10, ST_MARK = 4'd11, ST_OUT = 4'd12, ST_LWAIT = 4'd13;

   logic [COUNT_BITS-1:0] cnt_mem [CELLS];
   logic                  mark_mem [CELLS];

   logic [CS_BITS-1:0]  cell_size_ff;
   logic [5:0]          dim_x_ff, dim_y_ff, dim_z_ff;
   logic [9:0]          thr_ff;
   logic [4:0]          gap_ff;

   logic [3:0]            state_ff;
   logic [1:0]            kind_ff;
   logic [ADDR_BITS:0]    sweep_ff;
   logic [COORD_BITS-1:0] rem_ff, quo_ff, dvd_ff;
   logic [4:0]            bit_ff;
   logic [1:0]            axis_ff;
   logic [COORD_BITS-1:0] cx_ff, cy_ff, cz_ff;
   logic [DIM_BITS-1:0]   qx_ff, qy_ff, qz_ff;
   logic [DIM_BITS-1:0]   sx_ff, sy_ff, sz_ff;
   logic [3:0]            nb_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;
   logic                  rd_mark_ff;
   logic                  out_valid_ff;
   rsp_type               out_ff;

   // effective config
   logic [CS_BITS-1:0]  cs_eff;
   logic [6:0]          dx, dy, dz;
   function automatic logic [6:0] eff_dim(input logic [5:0] d);
      if (d == 6'd0) return 7'd1;
      if ({1'b0, d} > 7'(MAX_DIM)) return 7'(MAX_DIM);
      return {1'b0, d};
   endfunction
   assign cs_eff = (cell_size_ff == '0) ? CS_BITS'(1) : cell_size_ff;
   assign dx = eff_dim(dim_x_ff);
   assign dy = eff_dim(dim_y_ff);
   assign dz = eff_dim(dim_z_ff);

   // restoring divide step
   logic [COORD_BITS:0]   trial;
   logic [COORD_BITS-1:0] rem_sh;
   assign rem_sh = {rem_ff[COORD_BITS-2:0], dvd_ff[COORD_BITS-1]};
   assign trial = {rem_ff[COORD_BITS-1], rem_sh} - {5'd0, cs_eff};

   logic [6:0] dcur;
   always_comb begin
      case (axis_ff)
         2'd0: dcur = dx;
         2'd1: dcur = dy;
         default: dcur = dz;
      endcase
   end
   logic [COORD_BITS-1:0] qfin;
   logic [DIM_BITS-1:0]   qcl;
   assign qfin = {quo_ff[COORD_BITS-2:0], ~trial[COORD_BITS]};
   assign qcl = (qfin >= COORD_BITS'(dcur)) ? DIM_BITS'(dcur - 7'd1) : qfin[DIM_BITS-1:0];

   // neighbour offsets
   logic signed [7:0] ox, oy, nx, ny;
   logic              nb_ok;
   always_comb begin
      case (nb_ff)
         4'd0: begin ox = 8'sd0; oy = 8'sd0; end
         4'd1: begin ox = -8'sd1; oy = -8'sd1; end
         4'd2: begin ox = -8'sd1; oy = 8'sd0; end
         4'd3: begin ox = -8'sd1; oy = 8'sd1; end
         4'd4: begin ox = 8'sd0; oy = -8'sd1; end
         4'd5: begin ox = 8'sd0; oy = 8'sd1; end
         4'd6: begin ox = 8'sd1; oy = -8'sd1; end
         4'd7: begin ox = 8'sd1; oy = 8'sd0; end
         default: begin ox = 8'sd1; oy = 8'sd1; end
      endcase
      nx = $signed({2'b0, sx_ff}) + ox * $signed({3'b0, gap_ff});
      ny = $signed({2'b0, sy_ff}) + oy * $signed({3'b0, gap_ff});
      nb_ok = (nx >= 0) && (ny >= 0) && (nx < $signed({1'b0, dx}))
         && (ny < $signed({1'b0, dy}));
   end
   logic [DIM_BITS-1:0] zm;
   assign zm = DIM_BITS'({1'b0, sz_ff} - {1'b0, gap_ff} - 6'd1);

   // grid port address
   logic [ADDR_BITS-1:0] addr;
   always_comb begin
      case (state_ff)
         ST_LRD, ST_LWR: addr = {qz_ff, qy_ff, qx_ff};
         ST_NRD:  addr = {zm, DIM_BITS'(ny), DIM_BITS'(nx)};
         default: addr = {sz_ff, sy_ff, sx_ff};
      endcase
   end

   logic [COUNT_BITS-1:0] inc;
   assign inc = (rd_cnt_ff == COUNT_MAX) ? rd_cnt_ff : rd_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_CLEAR: begin
            cnt_mem[sweep_ff[ADDR_BITS-1:0]] <= '0;
            mark_mem[sweep_ff[ADDR_BITS-1:0]] <= 1'b0;
         end
         ST_MCLR: mark_mem[sweep_ff[ADDR_BITS-1:0]] <= 1'b0;
         ST_LWR: if (kind_ff == KIND_LOAD) cnt_mem[addr] <= inc;
         ST_MARK: mark_mem[addr] <= 1'b1;
         default: ;
      endcase
      rd_cnt_ff <= cnt_mem[addr];
      rd_mark_ff <= mark_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= CS_BITS'(1000);
         dim_x_ff <= 6'd32; dim_y_ff <= 6'd32; dim_z_ff <= 6'd32;
         thr_ff <= 10'd2; gap_ff <= 5'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_CELL_SIZE: cell_size_ff <= csr_data;
            REG_DIM_X: dim_x_ff <= csr_data[5:0];
            REG_DIM_Y: dim_y_ff <= csr_data[5:0];
            REG_DIM_Z: dim_z_ff <= csr_data[5:0];
            REG_THRESHOLD: thr_ff <= csr_data[9:0];
            REG_LEVEL_GAP: gap_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         kind_ff <= KIND_LOAD;
         sweep_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp.ready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR, ST_MCLR: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == (ADDR_BITS+1)'(CELLS - 1)) begin
                  if (state_ff == ST_CLEAR) begin
                     // the sweep after reset answers no transaction
                     state_ff <= (kind_ff == KIND_CLEAR) ? ST_OUT : ST_IDLE;
                  end else begin
                     sx_ff <= '0; sy_ff <= '0;
                     state_ff <= ST_COL;
                  end
               end
            end
            ST_IDLE: if (req.valid && req.ready) begin
               kind_ff <= req.payload.kind;
               cx_ff <= req.payload.coord_x;
               cy_ff <= req.payload.coord_y;
               cz_ff <= req.payload.coord_z;
               out_ff <= '0;
               sweep_ff <= '0;
               case (req.payload.kind)
                  KIND_SCAN: state_ff <= ST_MCLR;
                  KIND_CLEAR: state_ff <= ST_CLEAR;
                  default: begin
                     axis_ff <= 2'd0; rem_ff <= '0; quo_ff <= '0; bit_ff <= '0;
                     dvd_ff <= req.payload.coord_x;
                     state_ff <= ST_DIV;
                  end
               endcase
            end
            ST_DIV: begin
               rem_ff <= trial[COORD_BITS] ? rem_sh : trial[COORD_BITS-1:0];
               quo_ff <= qfin;
               dvd_ff <= {dvd_ff[COORD_BITS-2:0], 1'b0};
               bit_ff <= bit_ff + 1'b1;
               if (bit_ff == 5'(COORD_BITS - 1)) begin
                  bit_ff <= '0; rem_ff <= '0; quo_ff <= '0;
                  axis_ff <= axis_ff + 1'b1;
                  case (axis_ff)
                     2'd0: begin qx_ff <= qcl; dvd_ff <= cy_ff; end
                     2'd1: begin qy_ff <= qcl; dvd_ff <= cz_ff; end
                     default: begin qz_ff <= qcl; state_ff <= ST_LWAIT; end
                  endcase
               end
            end
            ST_LWAIT: state_ff <= ST_LRD;
            ST_LRD: state_ff <= ST_LWR;
            ST_LWR: begin
               out_ff.removed <= (kind_ff == KIND_CLASSIFY) ? rd_mark_ff : 1'b0;
               out_ff.voxel_count <= 11'((kind_ff == KIND_LOAD) ? inc : rd_cnt_ff);
               state_ff <= ST_OUT;
            end
            ST_COL: begin
               if ({1'b0, sx_ff} >= dx) begin
                  state_ff <= ST_OUT;
               end else begin
                  sz_ff <= DIM_BITS'(dz - 7'd1);
                  state_ff <= ((dz - 7'd1) > {2'b0, gap_ff}) ? ST_CRD : ST_CCHK;
                  if ((dz - 7'd1) <= {2'b0, gap_ff}) nb_ff <= 4'd15;
               end
            end
            ST_CRD: begin nb_ff <= '0; state_ff <= ST_CCHK; end
            ST_CCHK: begin
               if (nb_ff == 4'd15 || (rd_cnt_ff != '0 && COUNT_BITS'(thr_ff) < rd_cnt_ff
                     && 11'(rd_cnt_ff) > 11'(thr_ff))) begin
                  nb_ff <= '0;
                  if ({1'b0, sy_ff} + 6'd1 >= 6'(dy)) begin
                     sy_ff <= '0; sx_ff <= sx_ff + 1'b1;
                     if ({1'b0, sx_ff} + 6'd1 >= 6'(dx)) state_ff <= ST_OUT;
                     else state_ff <= ST_COL;
                  end else begin
                     sy_ff <= sy_ff + 1'b1; state_ff <= ST_COL;
                  end
               end else if (rd_cnt_ff == '0) begin
                  if ({1'b0, sz_ff} - 6'd1 > {1'b0, gap_ff}) begin
                     sz_ff <= sz_ff - 1'b1; state_ff <= ST_CRD;
                  end else nb_ff <= 4'd15;
               end else begin
                  nb_ff <= '0; state_ff <= ST_NRD;
               end
            end
            ST_NRD: begin
               if (nb_ff == 4'd9) state_ff <= ST_MARK;
               else if (nb_ok) state_ff <= ST_NCHK;
               else nb_ff <= nb_ff + 1'b1;
            end
            ST_NCHK: begin
               if (rd_cnt_ff != '0) begin
                  nb_ff <= 4'd15; state_ff <= ST_CCHK;
               end else begin
                  nb_ff <= nb_ff + 1'b1; state_ff <= ST_NRD;
               end
            end
            ST_MARK: begin
               if ({1'b0, sz_ff} - 6'd1 > {1'b0, gap_ff}) begin
                  sz_ff <= sz_ff - 1'b1; state_ff <= ST_CRD;
               end else begin
                  nb_ff <= 4'd15; state_ff <= ST_CCHK;
               end
            end
            ST_OUT: begin
               out_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
               if (kind_ff != KIND_LOAD && kind_ff != KIND_CLASSIFY) out_ff <= '0;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

@@ tb/tb_voxel_upper_outlier_filter_unit.sv @@
// tb_voxel_upper_outlier_filter_unit: self-checking bench for the voxel upper outlier filter
// uses vuof_pkg, vuof_req_if/vuof_rsp_if and voxel_upper_outlier_filter_unit
// an in-bench grid model predicts every response, which is compared field by field
`timescale 1ns / 100ps

module tb_voxel_upper_outlier_filter_unit;
   import vuof_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000000;

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [IDX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0] csr_data;

   vuof_req_if req ();
   vuof_rsp_if rsp ();

   voxel_upper_outlier_filter_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   // grid model
   logic [COUNT_BITS-1:0] grid_count [CELLS];
   bit                    grid_mark  [CELLS];
   int unsigned m_cell_size, m_dim_x, m_dim_y, m_dim_z, m_threshold, m_gap;

   rsp_type expected_rsp [$];
   int errors;
   int idle_pct, stall_pct;
   int idle_cycles;
   int kind_seen [4];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned eff_dim(int unsigned d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return d;
   endfunction

   function automatic int unsigned quantize(logic [COORD_BITS-1:0] c, int unsigned d);
      int unsigned cs, q;
      cs = (m_cell_size == 0) ? 1 : m_cell_size;
      q  = c / cs;
      return (q >= eff_dim(d)) ? eff_dim(d) - 1 : q;
   endfunction

   function automatic int unsigned cell_at(int unsigned x, int unsigned y, int unsigned z);
      return (z * MAX_DIM + y) * MAX_DIM + x;
   endfunction

   function automatic bit occ(int unsigned x, int unsigned y, int unsigned z);
      return grid_count[cell_at(x, y, z)] != 0;
   endfunction

   function automatic bit has_support(int unsigned x, int unsigned y, int unsigned zm,
                                      int unsigned dx, int unsigned dy);
      int unsigned g;
      bit lx, hx, ly, hy;
      g  = m_gap;
      lx = x >= g; hx = x + g < dx;
      ly = y >= g; hy = y + g < dy;
      if (occ(x, y, zm)) return 1;
      if (lx && ly && occ(x - g, y - g, zm)) return 1;
      if (lx && occ(x - g, y, zm)) return 1;
      if (lx && hy && occ(x - g, y + g, zm)) return 1;
      if (ly && occ(x, y - g, zm)) return 1;
      if (hy && occ(x, y + g, zm)) return 1;
      if (hx && ly && occ(x + g, y - g, zm)) return 1;
      if (hx && occ(x + g, y, zm)) return 1;
      if (hx && hy && occ(x + g, y + g, zm)) return 1;
      return 0;
   endfunction

   function automatic void mark_outliers();
      int unsigned dx, dy, dz, i;
      int z;
      dx = eff_dim(m_dim_x); dy = eff_dim(m_dim_y); dz = eff_dim(m_dim_z);
      foreach (grid_mark[k]) grid_mark[k] = 0;
      for (int unsigned x = 0; x < dx; x++)
         for (int unsigned y = 0; y < dy; y++)
            for (z = int'(dz) - 1; z > int'(m_gap); z--) begin
               i = cell_at(x, y, z);
               if (grid_count[i] == 0) continue;
               if (grid_count[i] > m_threshold) break;
               if (has_support(x, y, z - m_gap - 1, dx, dy)) break;
               grid_mark[i] = 1;
            end
   endfunction

   function automatic rsp_type predict_response(req_type t);
      rsp_type r;
      int unsigned i;
      r = '0;
      case (t.kind)
         KIND_LOAD, KIND_CLASSIFY: begin
            i = cell_at(quantize(t.coord_x, m_dim_x), quantize(t.coord_y, m_dim_y),
                        quantize(t.coord_z, m_dim_z));
            if (t.kind == KIND_LOAD) begin
               if (grid_count[i] != COUNT_MAX) grid_count[i] = grid_count[i] + 1;
            end else begin
               r.removed = grid_mark[i];
            end
            r.voxel_count = grid_count[i];
         end
         KIND_SCAN: mark_outliers();
         default: begin
            foreach (grid_count[k]) grid_count[k] = '0;
            foreach (grid_mark[k]) grid_mark[k] = 0;
         end
      endcase
      return r;
   endfunction

   function automatic void apply_register(logic [IDX_BITS-1:0] idx, logic [CSR_BITS-1:0] d);
      case (idx)
         REG_CELL_SIZE: m_cell_size = d[19:0];
         REG_DIM_X:     m_dim_x     = d[5:0];
         REG_DIM_Y:     m_dim_y     = d[5:0];
         REG_DIM_Z:     m_dim_z     = d[5:0];
         REG_THRESHOLD: m_threshold = d[9:0];
         REG_LEVEL_GAP: m_gap       = d[4:0];
         default: ;
      endcase
   endfunction

   // response side: random backpressure and checking
   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected response removed=%0d voxel_count=%0d",
                   rsp.payload.removed, rsp.payload.voxel_count);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp.payload.removed !== e.removed) begin
               $error("removed: expected %0d actual %0d", e.removed, rsp.payload.removed);
               errors++;
            end
            if (rsp.payload.voxel_count !== e.voxel_count) begin
               $error("voxel_count: expected %0d actual %0d", e.voxel_count,
                      rsp.payload.voxel_count);
               errors++;
            end
         end
      end
   end

   // watchdog on transaction activity
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses pending", expected_rsp.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // valid stays high between back-to-back transactions unless an idle gap is drawn; callers lower it via drain
   task automatic send_item(req_type t);
      if ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req.valid   <= 1'b1;
      req.payload <= t;
      do @(posedge clock); while (!req.ready);
      expected_rsp.push_back(predict_response(t));
      kind_seen[t.kind]++;
   endtask

   task automatic send_kind(logic [1:0] k, logic [23:0] x, logic [23:0] y, logic [23:0] z);
      req_type t;
      t.kind = k; t.coord_x = x; t.coord_y = y; t.coord_z = z;
      send_item(t);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_regs(int unsigned cs, int unsigned dx, int unsigned dy,
                             int unsigned dz, int unsigned th, int unsigned gap);
      logic [CSR_BITS-1:0] vals [6];
      vals = '{CSR_BITS'(cs), CSR_BITS'(dx), CSR_BITS'(dy), CSR_BITS'(dz), CSR_BITS'(th),
               CSR_BITS'(gap)};
      for (int i = 0; i < 6; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= i[IDX_BITS-1:0];
         csr_data         <= vals[i];
         @(posedge clock);
         apply_register(i[IDX_BITS-1:0], vals[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [23:0] coord_in(int unsigned v);
      int unsigned cs;
      cs = (m_cell_size == 0) ? 1 : m_cell_size;
      return 24'(v * cs + $urandom_range(cs - 1));
   endfunction

   task automatic send_point(logic [1:0] k, int unsigned vx, int unsigned vy, int unsigned vz);
      send_kind(k, coord_in(vx), coord_in(vy), coord_in(vz));
   endtask

   task automatic test_default_grid();
      send_kind(KIND_LOAD, 24'h0, 24'h0, 24'h0);
      send_kind(KIND_LOAD, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_point(KIND_LOAD, 10, 10, 20);
      send_point(KIND_LOAD, 5, 5, 6);
      send_point(KIND_LOAD, 6, 6, 4);
      send_point(KIND_LOAD, 20, 20, 9);
      send_point(KIND_LOAD, 20, 20, 9);
      send_point(KIND_LOAD, 20, 20, 9);
      send_kind(KIND_SCAN, 24'h0, 24'h0, 24'h0);
      send_point(KIND_CLASSIFY, 10, 10, 20);
      send_point(KIND_CLASSIFY, 5, 5, 6);
      send_point(KIND_CLASSIFY, 20, 20, 9);
      send_kind(KIND_CLASSIFY, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_kind(KIND_CLEAR, 24'hFFFFFF, 24'h0, 24'hFFFFFF);
      send_kind(KIND_CLASSIFY, 24'h0, 24'h0, 24'h0);
      drain();
   endtask

   task automatic test_register_extremes();
      // zero cell size, clamped dimensions, widest gap, ignored indexes
      write_regs(0, 0, 63, 33, 1000, 31);
      for (int i = 6; i < 8; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= i[IDX_BITS-1:0];
         csr_data         <= CSR_BITS'($urandom());
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      send_kind(KIND_LOAD, 24'd3, 24'd4, 24'd5);
      send_kind(KIND_LOAD, 24'd40, 24'd50, 24'd31);
      send_kind(KIND_SCAN, 24'hFFFFFF, 24'hFFFFFF, 24'h0);
      send_kind(KIND_CLASSIFY, 24'd40, 24'd50, 24'd31);
      send_kind(KIND_CLASSIFY, 24'd3, 24'd4, 24'd5);
      drain();
      write_regs(1000000, 2, 2, 4, 1, 0);
      send_kind(KIND_LOAD, 24'd0, 24'd0, 24'hFFFFFF);
      send_kind(KIND_LOAD, 24'd999999, 24'd1000000, 24'd1000000);
      send_kind(KIND_SCAN, 24'd0, 24'd0, 24'd0);
      send_kind(KIND_CLASSIFY, 24'd0, 24'd0, 24'hFFFFFF);
      send_kind(KIND_CLASSIFY, 24'd999999, 24'd1000000, 24'd1000000);
      drain();
   endtask

   task automatic pick_voxel(output int unsigned vx, output int unsigned vy,
                             output int unsigned vz);
      int unsigned dx, dy, dz;
      dx = eff_dim(m_dim_x); dy = eff_dim(m_dim_y); dz = eff_dim(m_dim_z);
      vx = $urandom_range(dx - 1);
      vy = $urandom_range(dy - 1);
      if ($urandom_range(1)) vz = $urandom_range((dz > 2) ? 1 : dz - 1);
      else vz = $urandom_range(dz - 1);
   endtask

   task automatic test_random_phase(int idle, int stall, int n_items);
      int unsigned vx, vy, vz, sel;
      idle_pct  = idle;
      stall_pct = stall;
      write_regs($urandom_range(1, 4000), $urandom_range(2, 8), $urandom_range(2, 8),
                 $urandom_range(3, 8), $urandom_range(1, 4), $urandom_range(0, 2));
      send_kind(KIND_CLEAR, 24'($urandom()), 24'($urandom()), 24'($urandom()));
      for (int n = 0; n < n_items; n++) begin
         sel = $urandom_range(99);
         pick_voxel(vx, vy, vz);
         if (n == n_items / 2 || n == n_items - 40)
            send_kind(KIND_SCAN, 24'($urandom()), 24'($urandom()), 24'($urandom()));
         else if (sel < 55) send_point(KIND_LOAD, vx, vy, vz);
         else if (sel < 88) send_point(KIND_CLASSIFY, vx, vy, vz);
         else send_kind($urandom_range(1) ? KIND_LOAD : KIND_CLASSIFY,
                        24'($urandom()), 24'($urandom()), 24'($urandom()));
      end
      drain();
   endtask

   initial begin
      reset            = 1'b1;
      req.valid        = 1'b0;
      req.payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      errors           = 0;
      idle_pct         = 0;
      stall_pct        = 0;
      foreach (grid_count[k]) grid_count[k] = '0;
      foreach (grid_mark[k]) grid_mark[k] = 0;
      m_cell_size = 1000; m_dim_x = 32; m_dim_y = 32; m_dim_z = 32;
      m_threshold = 2; m_gap = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_grid();
      test_register_extremes();
      test_random_phase(0, 0, 330);
      test_random_phase(78, 0, 320);
      test_random_phase(0, 78, 320);
      test_random_phase(30, 30, 320);

      repeat (200) @(posedge clock);
      $display("covered %0d loads, %0d scans, %0d classifies, %0d clears",
               kind_seen[KIND_LOAD], kind_seen[KIND_SCAN], kind_seen[KIND_CLASSIFY],
               kind_seen[KIND_CLEAR]);
      $display("across default, extreme and random register settings with idle and stall");
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
